FILE: design/tts_pkg.sv
// Package: payload types, calendar constants and the month length table.
`timescale 1ns / 1ps
package tts_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTRA = 1'b1;

  // Zone arithmetic, in minutes
  localparam logic signed [11:0] CLOCK_ZONE_MIN = 12'sd540;
  localparam logic signed [11:0] DST_MIN        = 12'sd60;
  localparam logic signed [11:0] MIN_PER_DAY    = 12'sd1440;
  localparam logic signed [10:0] ZONE_LOW       = -11'sd720;
  localparam logic signed [10:0] ZONE_HIGH      = 11'sd840;
  localparam int unsigned        DST_BIT        = 4;

  // Calendar limits
  localparam logic [15:0] YEAR_MAX   = 16'd9999;
  localparam logic [7:0]  MONTH_MAX  = 8'd12;
  localparam logic [7:0]  HOUR_MAX   = 8'd23;
  localparam logic [7:0]  MINUTE_MAX = 8'd59;

  typedef struct packed {
    logic [15:0] in_year;
    logic [7:0]  in_month;
    logic [7:0]  in_day;
    logic [7:0]  in_hour;
    logic [7:0]  in_minute;
  } tts_in_t;

  typedef struct packed {
    logic [15:0] out_year;
    logic [7:0]  out_month;
    logic [7:0]  out_day;
    logic [7:0]  out_hour;
    logic [7:0]  out_minute;
    logic        converted;
  } tts_out_t;

  // Days in a month; months outside 1..12 read as 31
  function automatic logic [4:0] month_len(input logic [7:0] month, input logic leap);
    logic [4:0] len;
    if (month == 8'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (month inside {8'd4, 8'd6, 8'd9, 8'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

FILE: design/tts_config.sv
// Configuration registers and the registered local zone shift.
`timescale 1ns / 1ps
module tts_config (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_wdata,
  output logic signed [11:0]                delta
);
  import tts_pkg::*;

  logic [31:0]        osd_config_word;
  logic [7:0]         osd_config_extra;
  logic [2:0]         version;
  logic signed [10:0] zone;
  logic               zone_ok;
  logic signed [11:0] dst_add;
  logic signed [11:0] delta_next;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      osd_config_word  <= '0;
      osd_config_extra <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORD:  osd_config_word  <= cfg_wdata;
        CFG_EXTRA: osd_config_extra <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Decode the zone and form the shift relative to the clock zone
  always_comb begin
    version = osd_config_word[15:13];
    zone    = $signed(osd_config_word[31:21]);
    zone_ok = (zone >= ZONE_LOW) && (zone <= ZONE_HIGH);
    dst_add = osd_config_extra[DST_BIT] ? DST_MIN : 12'sd0;
    if (version == 3'd0 || !zone_ok) begin
      delta_next = 12'sd0;
    end else begin
      delta_next = $signed({zone[10], zone}) + dst_add - CLOCK_ZONE_MIN;
    end
  end

  // Hold the shift in a register
  always_ff @(posedge clk) begin
    if (rst) begin
      delta <= 12'sd0;
    end else begin
      delta <= delta_next;
    end
  end

endmodule

FILE: design/tts_convert.sv
// Stamp validation and the shift with one-day date carry or borrow.
`timescale 1ns / 1ps
module tts_convert (
  input  tts_pkg::tts_in_t   stamp,
  input  logic signed [11:0] delta,
  output tts_pkg::tts_out_t  result
);
  import tts_pkg::*;

  logic [15:0]        y;
  logic [7:0]         m;
  logic [7:0]         d;
  logic [13:0]        y14;
  logic [28:0]        y_prod;
  logic [13:0]        y_q;
  logic [13:0]        y_q25;
  logic               div25;
  logic               leap;
  logic [4:0]         mlen;
  logic [7:0]         m_prev;
  logic [4:0]         mlen_prev;
  logic               valid;
  logic [11:0]        mday;
  logic signed [11:0] t;
  logic [10:0]        tw;
  logic [21:0]        h_prod;
  logic [4:0]         hour;
  logic [10:0]        rem;
  logic [15:0]        y_new;
  logic [7:0]         m_new;
  logic [7:0]         d_new;

  always_comb begin
    y = stamp.in_year;
    m = stamp.in_month;
    d = stamp.in_day;

    // Leap test: divisibility by 25 through a reciprocal multiply
    y14    = y[13:0];
    y_prod = 29'(y14) * 29'd20972;
    y_q    = {4'b0, y_prod[28:19]};
    y_q25  = (y_q << 4) + (y_q << 3) + y_q;
    div25  = (y_q25 == y14);
    leap   = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));

    // Month lengths; a borrow into December needs no leap test of the year before
    mlen      = month_len(m, leap);
    m_prev    = (m > 8'd1) ? m - 8'd1 : MONTH_MAX;
    mlen_prev = month_len(m_prev, leap);

    valid = (y != 16'd0) && (y <= YEAR_MAX) && (m != 8'd0) && (m <= MONTH_MAX)
         && (d != 8'd0) && (d <= {3'b0, mlen})
         && (stamp.in_hour <= HOUR_MAX) && (stamp.in_minute <= MINUTE_MAX);

    // Minutes of the day after the shift
    mday = (12'(stamp.in_hour[4:0]) << 6) - (12'(stamp.in_hour[4:0]) << 2)
         + 12'(stamp.in_minute[5:0]);
    t    = $signed(mday) + delta;

    // Wrap over one day and step the date
    y_new = y;
    m_new = m;
    d_new = d;
    if (t[11]) begin
      tw = 11'(t + MIN_PER_DAY);
      if (d > 8'd1) begin
        d_new = d - 8'd1;
      end else begin
        m_new = m_prev;
        d_new = {3'b0, mlen_prev};
        if (m <= 8'd1) begin
          y_new = y - 16'd1;
        end
      end
    end else if (t >= MIN_PER_DAY) begin
      tw = 11'(t - MIN_PER_DAY);
      if (d < {3'b0, mlen}) begin
        d_new = d + 8'd1;
      end else begin
        d_new = 8'd1;
        if (m < MONTH_MAX) begin
          m_new = m + 8'd1;
        end else begin
          m_new = 8'd1;
          y_new = y + 16'd1;
        end
      end
    end else begin
      tw = 11'(t);
    end

    // Split into hour and minute: divide by 60 as a reciprocal multiply
    h_prod = 22'(tw) * 22'd1093;
    hour   = h_prod[20:16];
    rem    = tw - ((11'(hour) << 6) - (11'(hour) << 2));

    if (valid) begin
      result.out_year   = y_new;
      result.out_month  = m_new;
      result.out_day    = d_new;
      result.out_hour   = 8'(hour);
      result.out_minute = 8'(rem[5:0]);
      result.converted  = 1'b1;
    end else begin
      result.out_year   = y;
      result.out_month  = m;
      result.out_day    = d;
      result.out_hour   = stamp.in_hour;
      result.out_minute = stamp.in_minute;
      result.converted  = 1'b0;
    end
  end

endmodule

FILE: design/timestamp_timezone_shift.sv
// A stamp passes the input register, then the result register, and is offered
// from there. Throughput: one stamp per cycle while out_stall is low; the input
// register and the result register make a two-entry pipeline, so a new stamp
// is taken while a result still waits under stall.
// Reset (rst, synchronous, active high) empties the pipeline and clears both
// configuration registers, which leaves the local zone equal to the clock zone.
`timescale 1ns / 1ps
module timestamp_timezone_shift (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tts_pkg::tts_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tts_pkg::tts_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [tts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_wdata
);
  import tts_pkg::*;

  logic               s0_valid;
  tts_in_t            s0_data;
  tts_out_t           conv;
  logic signed [11:0] delta;
  logic               advance;

  tts_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .delta     (delta)
  );

  tts_convert u_convert (
    .stamp  (s0_data),
    .delta  (delta),
    .result (conv)
  );

  // Advance whenever the result register is free or being emptied
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s0_valid && !advance;

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s0_valid;
      end
      if (!in_stall) begin
        s0_valid <= in_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_data <= in_data;
    end
    if (advance && s0_valid) begin
      out_data <= conv;
    end
  end

  // Converted stamps carry a legal time of day
  a_time_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.converted |->
      out_data.out_hour <= HOUR_MAX && out_data.out_minute <= MINUTE_MAX)
    else $error("converted time of day out of range");

  // Converted stamps carry a legal month
  a_month_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.converted |->
      out_data.out_month != 8'd0 && out_data.out_month <= MONTH_MAX)
    else $error("converted month out of range");

  // Input stalls only when both stages are full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s0_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s0_valid)
    else $error("pipeline not empty after reset");

endmodule
